[sv/ps2mpt_pkg.sv]
// Shared types and constants of the PS/2 mouse packet tracker.
package ps2mpt_pkg;

    localparam int BYTE_W  = 8;
    localparam int SIZE_W  = 13;
    localparam int POS_W   = 12;
    localparam int BTN_W   = 3;
    localparam int DELTA_W = 10;
    localparam int CFG_IDX_W = 1;

    // Bit positions inside the packet header byte.
    localparam int HDR_SYNC_BIT   = 3;
    localparam int HDR_X_SIGN_BIT = 4;
    localparam int HDR_Y_SIGN_BIT = 5;

    localparam logic [SIZE_W-1:0] WIDTH_RESET  = SIZE_W'(800);
    localparam logic [SIZE_W-1:0] HEIGHT_RESET = SIZE_W'(600);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SCREEN_WIDTH  = 1'b0,
        CFG_SCREEN_HEIGHT = 1'b1
    } t_cfg_idx;

endpackage

[sv/ps2mpt_ifs.sv]
// Channel interfaces of the PS/2 mouse packet tracker: bytes, positions, configuration.
interface ps2mpt_byte_if;
    logic                            valid;
    logic                            ready;
    logic [ps2mpt_pkg::BYTE_W-1:0]   rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface ps2mpt_pos_if;
    logic                            valid;
    logic                            ready;
    logic [ps2mpt_pkg::POS_W-1:0]    pos_x;
    logic [ps2mpt_pkg::POS_W-1:0]    pos_y;
    logic [ps2mpt_pkg::BTN_W-1:0]    buttons;

    modport source (output valid, output pos_x, output pos_y, output buttons, input ready);
    modport sink   (input valid, input pos_x, input pos_y, input buttons, output ready);
endinterface

interface ps2mpt_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [ps2mpt_pkg::CFG_IDX_W-1:0] index;
    logic [ps2mpt_pkg::SIZE_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[sv/ps2mpt_axis.sv]
// One cursor axis: adds a signed delta and clamps the result to the screen size.
module ps2mpt_axis #(
    parameter int CW          = 12,
    parameter int COORD_LIMIT = 4096
) (
    input  logic [CW-1:0]                         i_cursor,
    input  logic signed [ps2mpt_pkg::DELTA_W-1:0] i_delta,
    input  logic [ps2mpt_pkg::SIZE_W-1:0]         i_size,
    output logic [CW-1:0]                         o_cursor
);

    localparam int CALC_W = ((CW > ps2mpt_pkg::SIZE_W) ? CW : ps2mpt_pkg::SIZE_W) + 2;
    localparam logic signed [CALC_W-1:0] LIMIT_C = CALC_W'(COORD_LIMIT);

    logic signed [CALC_W-1:0] sum;
    logic signed [CALC_W-1:0] size_ext;
    logic signed [CALC_W-1:0] lim;

    always_comb begin
        sum      = $signed(CALC_W'(i_cursor)) + CALC_W'(i_delta);
        size_ext = $signed(CALC_W'(i_size));

        // A zero size behaves as one, and sizes beyond the coordinate range saturate.
        if (size_ext < CALC_W'(1)) begin
            lim = CALC_W'(1);
        end else if (size_ext > LIMIT_C) begin
            lim = LIMIT_C;
        end else begin
            lim = size_ext;
        end

        if (sum < CALC_W'(0)) begin
            o_cursor = '0;
        end else if (sum >= lim) begin
            o_cursor = CW'(lim - CALC_W'(1));
        end else begin
            o_cursor = CW'(sum);
        end
    end

endmodule

[sv/ps2_mouse_packet_tracker.sv]
// Top level of the PS/2 mouse packet tracker.
//
// Mouse bytes arrive as transfers on i_byte. Three bytes form a packet:
// a header whose sync bit (bit 3) must be set, an X delta and a Y delta.
// A byte expected as a header without the sync bit is dropped. The third
// byte of a packet moves the cursor (X plus dx, Y minus dy, both nine-bit
// signed with sign bits from the header) and clamps it to the screen;
// one transfer on o_pos then carries the position and the button bits.
// The other two bytes of a packet produce no output transfer.
//
// Each byte is taken into an input register and processed from there; the
// position that a packet's last byte produces is registered in the output register
// that drives o_pos. One byte per cycle is sustained: the input only stalls when a
// finishing packet meets a full output register the receiver is not draining,
// and then just that byte waits in the input register.
//
// i_cfg writes screen width (index 0) and screen height (index 1); it is
// always ready and should be used only while no packet is in progress.
// Reset restores width 800, height 600, the cursor to its start point,
// empties both pipeline registers and waits for a header byte.
module ps2_mouse_packet_tracker #(
    parameter int COORD_LIMIT = 4096,
    parameter int START_X     = 400,
    parameter int START_Y     = 300
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    ps2mpt_byte_if.sink   i_byte,
    ps2mpt_cfg_if.sink    i_cfg,
    ps2mpt_pos_if.source  o_pos
);

    // The cursor register holds every clamped value and both start points.
    localparam int MAX_A   = (COORD_LIMIT > START_X + 1) ? COORD_LIMIT : START_X + 1;
    localparam int CUR_MAX = (MAX_A > START_Y + 1) ? MAX_A : START_Y + 1;
    localparam int CW      = $clog2(CUR_MAX);
    localparam int EXT_W   = (CW > ps2mpt_pkg::POS_W) ? CW : ps2mpt_pkg::POS_W;

    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_XDELTA = 2'd1,
        PH_YDELTA = 2'd2
    } t_phase;

    // Configuration registers.
    logic [ps2mpt_pkg::SIZE_W-1:0] r_width;
    logic [ps2mpt_pkg::SIZE_W-1:0] r_height;

    // Input register.
    logic                          r_in_valid;
    logic [ps2mpt_pkg::BYTE_W-1:0] r_in_byte;

    // Packet assembly state.
    t_phase                        r_phase;
    t_phase                        n_phase;
    logic [ps2mpt_pkg::BYTE_W-1:0] r_header;
    logic [ps2mpt_pkg::BYTE_W-1:0] n_header;
    logic [ps2mpt_pkg::BYTE_W-1:0] r_xbyte;
    logic [ps2mpt_pkg::BYTE_W-1:0] n_xbyte;
    logic [CW-1:0]                 r_cur_x;
    logic [CW-1:0]                 r_cur_y;

    // Output register.
    logic                          r_out_valid;
    logic [ps2mpt_pkg::POS_W-1:0]  r_pos_x;
    logic [ps2mpt_pkg::POS_W-1:0]  r_pos_y;
    logic [ps2mpt_pkg::BTN_W-1:0]  r_buttons;

    logic                                 out_free;
    logic                                 finishes;
    logic                                 advance;
    logic                                 in_take;
    logic signed [ps2mpt_pkg::DELTA_W-1:0] dx;
    logic signed [ps2mpt_pkg::DELTA_W-1:0] dy;
    logic signed [ps2mpt_pkg::DELTA_W-1:0] neg_dy;
    logic [CW-1:0]                        new_x;
    logic [CW-1:0]                        new_y;

    assign out_free = !r_out_valid || o_pos.ready;
    assign finishes = r_in_valid && (r_phase == PH_YDELTA);
    // The held byte moves on unless it finishes a packet and the output is stalled.
    assign advance  = r_in_valid && (!finishes || out_free);
    assign in_take  = i_byte.valid && i_byte.ready;

    assign i_byte.ready = !r_in_valid || advance;
    assign i_cfg.ready  = 1'b1;

    assign dx = $signed({{(ps2mpt_pkg::DELTA_W - ps2mpt_pkg::BYTE_W)
                          {r_header[ps2mpt_pkg::HDR_X_SIGN_BIT]}}, r_xbyte});
    assign dy = $signed({{(ps2mpt_pkg::DELTA_W - ps2mpt_pkg::BYTE_W)
                          {r_header[ps2mpt_pkg::HDR_Y_SIGN_BIT]}}, r_in_byte});
    assign neg_dy = -dy;

    ps2mpt_axis #(
        .CW          (CW),
        .COORD_LIMIT (COORD_LIMIT)
    ) u_axis_x (
        .i_cursor (r_cur_x),
        .i_delta  (dx),
        .i_size   (r_width),
        .o_cursor (new_x)
    );

    ps2mpt_axis #(
        .CW          (CW),
        .COORD_LIMIT (COORD_LIMIT)
    ) u_axis_y (
        .i_cursor (r_cur_y),
        .i_delta  (neg_dy),
        .i_size   (r_height),
        .o_cursor (new_y)
    );

    // Next packet phase and the stored header and X delta bytes.
    always_comb begin
        n_phase  = r_phase;
        n_header = r_header;
        n_xbyte  = r_xbyte;
        case (r_phase)
            PH_XDELTA: begin
                n_xbyte = r_in_byte;
                n_phase = PH_YDELTA;
            end
            PH_YDELTA: begin
                n_phase = PH_HEADER;
            end
            default: begin
                // A byte without the sync bit cannot start a packet and is dropped.
                n_phase = PH_HEADER;
                if (r_in_byte[ps2mpt_pkg::HDR_SYNC_BIT]) begin
                    n_header = r_in_byte;
                    n_phase  = PH_XDELTA;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width     <= ps2mpt_pkg::WIDTH_RESET;
            r_height    <= ps2mpt_pkg::HEIGHT_RESET;
            r_in_valid  <= 1'b0;
            r_phase     <= PH_HEADER;
            r_header    <= '0;
            r_xbyte     <= '0;
            r_cur_x     <= CW'(START_X);
            r_cur_y     <= CW'(START_Y);
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                case (i_cfg.index)
                    ps2mpt_pkg::CFG_SCREEN_WIDTH:  r_width  <= i_cfg.data;
                    ps2mpt_pkg::CFG_SCREEN_HEIGHT: r_height <= i_cfg.data;
                    default: ;
                endcase
            end

            if (in_take) begin
                r_in_valid <= 1'b1;
                r_in_byte  <= i_byte.rx_byte;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end

            if (advance) begin
                r_phase  <= n_phase;
                r_header <= n_header;
                r_xbyte  <= n_xbyte;
            end

            if (advance && finishes) begin
                r_cur_x     <= new_x;
                r_cur_y     <= new_y;
                r_out_valid <= 1'b1;
                r_pos_x     <= ps2mpt_pkg::POS_W'(EXT_W'(new_x));
                r_pos_y     <= ps2mpt_pkg::POS_W'(EXT_W'(new_y));
                r_buttons   <= r_header[ps2mpt_pkg::BTN_W-1:0];
            end else if (o_pos.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_pos.valid   = r_out_valid;
    assign o_pos.pos_x   = r_pos_x;
    assign o_pos.pos_y   = r_pos_y;
    assign o_pos.buttons = r_buttons;

endmodule

[test/testbench.sv]
// Self-checking testbench of the PS/2 mouse packet tracker: directed table, random packets.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    // The block runs with its default start point; the predictor uses the same values.
    localparam int START_X     = 400;
    localparam int START_Y     = 300;
    localparam int COORD_LIMIT = 4096;

    localparam int PHASE_ITEMS   = 75;      // counted bytes per random phase
    localparam int SETTLE_CYCLES = 4;       // two-stage pipeline plus margin
    localparam int LONG_HOLD     = 300;     // receiver hold-off that backs up the block
    localparam int CYCLE_LIMIT   = 400000;

    localparam logic [ps2mpt_pkg::BYTE_W-1:0] SYNC_MASK =
        ps2mpt_pkg::BYTE_W'(1) << ps2mpt_pkg::HDR_SYNC_BIT;
    localparam int BYTE_SPAN = 1 << ps2mpt_pkg::BYTE_W;

    // Which byte of a packet the block waits for next.
    typedef enum logic [1:0] {
        PH_HEADER,
        PH_XDELTA,
        PH_YDELTA
    } t_pkt_phase;

    // Receiver stall patterns.
    typedef enum int {
        RX_ALWAYS,
        RX_COIN,
        RX_COMB
    } t_rx_mode;

    typedef struct packed {
        logic [ps2mpt_pkg::POS_W-1:0] pos_x;
        logic [ps2mpt_pkg::POS_W-1:0] pos_y;
        logic [ps2mpt_pkg::BTN_W-1:0] buttons;
    } t_pos;

    // One row of the directed table: the byte, and where the result can be read off
    // at a glance, the position it must produce.
    typedef struct packed {
        logic [ps2mpt_pkg::BYTE_W-1:0] rx;
        bit                            typed;
        t_pos                          pos;
    } t_stim_row;

    logic i_clk = 1'b0;
    logic i_rst_n;

    ps2mpt_byte_if byte_ch ();
    ps2mpt_cfg_if  cfg_ch ();
    ps2mpt_pos_if  pos_ch ();

    ps2_mouse_packet_tracker #(
        .COORD_LIMIT (COORD_LIMIT),
        .START_X     (START_X),
        .START_Y     (START_Y)
    ) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_byte  (byte_ch),
        .i_cfg   (cfg_ch),
        .o_pos   (pos_ch)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Shadow copy of the block's state, starting at its reset values.
    logic [ps2mpt_pkg::SIZE_W-1:0] width_q  = ps2mpt_pkg::WIDTH_RESET;
    logic [ps2mpt_pkg::SIZE_W-1:0] height_q = ps2mpt_pkg::HEIGHT_RESET;
    t_pkt_phase                    pkt_phase = PH_HEADER;
    logic [ps2mpt_pkg::BYTE_W-1:0] hdr_q    = '0;
    logic [ps2mpt_pkg::BYTE_W-1:0] xdelta_q = '0;
    int                            cur_x    = START_X;
    int                            cur_y    = START_Y;

    // Positions still owed by the block, oldest first.
    t_pos pending_pos [$];

    int  error_count   = 0;
    int  cycle_count   = 0;
    int  burst_left    = 0;
    bit  full_rate     = 1'b0;
    bit  long_hold_req = 1'b0;

    // Directed bytes. Two bytes without the sync bit are dropped first, then packets
    // cover the button bits, the largest positive and negative deltas, set overflow
    // bits, minus one, and a move that clamps X at zero.
    t_stim_row directed_rows [23] = '{
        '{8'h00, 1'b0, '0},                     // no sync bit: dropped
        '{8'hF7, 1'b0, '0},                     // every bit but sync: dropped
        '{8'h08, 1'b0, '0},                     // zero move straight after reset
        '{8'h00, 1'b0, '0},
        '{8'h00, 1'b1, '{12'd400, 12'd300, 3'd0}},
        '{8'h0F, 1'b0, '0},                     // all buttons, +127 / +127
        '{8'h7F, 1'b0, '0},
        '{8'h7F, 1'b0, '0},
        '{8'h38, 1'b0, '0},                     // both signs, -128 / -128
        '{8'h80, 1'b0, '0},
        '{8'h80, 1'b0, '0},
        '{8'hC9, 1'b0, '0},                     // overflow bits set, +1 / +255
        '{8'h01, 1'b0, '0},
        '{8'hFF, 1'b0, '0},
        '{8'h3C, 1'b0, '0},                     // both signs with zero bytes: -256 / -256
        '{8'h00, 1'b0, '0},
        '{8'h00, 1'b0, '0},
        '{8'h1A, 1'b0, '0},                     // X sign with 0xFF: minus one
        '{8'hFF, 1'b0, '0},
        '{8'h00, 1'b0, '0},
        '{8'h18, 1'b0, '0},                     // -256 on X: clamps at zero
        '{8'h00, 1'b0, '0},
        '{8'h00, 1'b0, '0}
    };

    // A size register of zero behaves as one and anything above the coordinate
    // limit behaves as the limit.
    function automatic int screen_limit(input logic [ps2mpt_pkg::SIZE_W-1:0] size_val);
        int lim = int'(size_val);
        if (lim < 1) lim = 1;
        if (lim > COORD_LIMIT) lim = COORD_LIMIT;
        return lim;
    endfunction

    function automatic int clamp_coord(input int v, input int lim);
        if (v < 0) v = 0;
        if (v >= lim) v = lim - 1;
        return v;
    endfunction

    // Feeds one accepted byte to the shadow state; returns 1 and the new position
    // when the byte completes a packet.
    function automatic bit advance_cursor(input logic [ps2mpt_pkg::BYTE_W-1:0] b,
                                          output t_pos res);
        int dx;
        int dy;
        res = '0;
        advance_cursor = 1'b0;
        if (pkt_phase == PH_XDELTA) begin
            xdelta_q  = b;
            pkt_phase = PH_YDELTA;
        end else if (pkt_phase == PH_YDELTA) begin
            pkt_phase = PH_HEADER;
            // Nine-bit deltas: the sign bits live in the header byte.
            dx = int'(xdelta_q) - (hdr_q[ps2mpt_pkg::HDR_X_SIGN_BIT] ? BYTE_SPAN : 0);
            dy = int'(b) - (hdr_q[ps2mpt_pkg::HDR_Y_SIGN_BIT] ? BYTE_SPAN : 0);
            cur_x = clamp_coord(cur_x + dx, screen_limit(width_q));
            cur_y = clamp_coord(cur_y - dy, screen_limit(height_q));
            res.pos_x   = cur_x[ps2mpt_pkg::POS_W-1:0];
            res.pos_y   = cur_y[ps2mpt_pkg::POS_W-1:0];
            res.buttons = hdr_q[ps2mpt_pkg::BTN_W-1:0];
            advance_cursor = 1'b1;
        end else if (b[ps2mpt_pkg::HDR_SYNC_BIT]) begin
            hdr_q     = b;
            pkt_phase = PH_XDELTA;
        end
    endfunction

    task automatic report_mismatch(input string msg);
        error_count++;
        $display("MISMATCH at %0t ns: %s", $time, msg);
    endtask

    // Offers one byte and waits for its transfer. Valid is left high so that a
    // following byte can go out in the very next cycle. The prediction is made at
    // the accepting edge; a typed position, where given, replaces the predicted one.
    // counted is low for a byte the block drops.
    task automatic send_byte(input logic [ps2mpt_pkg::BYTE_W-1:0] b, input bit typed,
                             input t_pos typed_pos, output bit counted);
        t_pos       predicted;
        t_pkt_phase phase_was;
        byte_ch.valid   <= 1'b1;
        byte_ch.rx_byte <= b;
        do @(posedge i_clk); while (!byte_ch.ready);
        phase_was = pkt_phase;
        if (advance_cursor(b, predicted))
            pending_pos.push_back(typed ? typed_pos : predicted);
        counted = !(phase_was == PH_HEADER && !b[ps2mpt_pkg::HDR_SYNC_BIT]);
    endtask

    // The sender works in bursts; between bursts valid drops for a random number of
    // cycles, unless the current stretch runs at full rate.
    task automatic pace();
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = full_rate ? 0 : $urandom_range(0, 8);
            if (gap > 0) begin
                byte_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
    endtask

    // Deltas: half the time any byte, otherwise a small step either way.
    function automatic logic [ps2mpt_pkg::BYTE_W-1:0] pick_delta();
        if ($urandom_range(0, 1))
            return ps2mpt_pkg::BYTE_W'($urandom);
        return $urandom_range(0, 1) ? ps2mpt_pkg::BYTE_W'($urandom_range(0, 15))
                                    : ps2mpt_pkg::BYTE_W'(BYTE_SPAN - $urandom_range(1, 16));
    endfunction

    // Finishes any packet in progress, stops the sender and waits until every owed
    // position has been transferred and the pipeline has settled.
    task automatic drain_packets();
        bit counted;
        while (pkt_phase != PH_HEADER) begin
            pace();
            send_byte(pick_delta(), 1'b0, '0, counted);
        end
        byte_ch.valid <= 1'b0;
        while (pending_pos.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input ps2mpt_pkg::t_cfg_idx idx,
                             input logic [ps2mpt_pkg::SIZE_W-1:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do @(posedge i_clk); while (!cfg_ch.ready);
        if (idx == ps2mpt_pkg::CFG_SCREEN_WIDTH)
            width_q = val;
        else
            height_q = val;
    endtask

    // Size registers change only while the block is idle.
    task automatic set_screen(input logic [ps2mpt_pkg::SIZE_W-1:0] w,
                              input logic [ps2mpt_pkg::SIZE_W-1:0] h);
        drain_packets();
        write_reg(ps2mpt_pkg::CFG_SCREEN_WIDTH, w);
        write_reg(ps2mpt_pkg::CFG_SCREEN_HEIGHT, h);
        cfg_ch.valid <= 1'b0;
    endtask

    // Mostly well-formed packets with random content; the rest single random bytes,
    // which may be dropped, start a packet, or land as deltas of a broken one.
    // With squeeze set, the receiver's long hold-off starts a third of the way in.
    task automatic random_traffic(input int goal, input bit squeeze);
        int  taken;
        bit  counted;
        taken = 0;
        while (taken < goal) begin
            if (squeeze && !long_hold_req && taken >= goal / 3)
                long_hold_req <= 1'b1;
            if ($urandom_range(0, 9) < 8) begin
                pace();
                send_byte(ps2mpt_pkg::BYTE_W'($urandom) | SYNC_MASK, 1'b0, '0, counted);
                taken += counted;
                pace();
                send_byte(pick_delta(), 1'b0, '0, counted);
                taken += counted;
                pace();
                send_byte(pick_delta(), 1'b0, '0, counted);
                taken += counted;
            end else begin
                pace();
                send_byte(ps2mpt_pkg::BYTE_W'($urandom), 1'b0, '0, counted);
                taken += counted;
            end
        end
    endtask

    // Receiver: changes its stall pattern after random stretches of cycles, and once, on
    // request, holds ready low for a long stretch so the block fills and stalls
    // its input while the sender keeps offering bytes.
    initial begin
        t_rx_mode mode;
        int       mode_left;
        int       tick;
        int       hold_left;
        bit       hold_done;
        mode      = RX_ALWAYS;
        mode_left = 0;
        tick      = 0;
        hold_left = 0;
        hold_done = 1'b0;
        pos_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            tick++;
            if (hold_left > 0) begin
                hold_left--;
                pos_ch.ready <= 1'b0;
            end else if (long_hold_req && !hold_done) begin
                hold_done = 1'b1;
                hold_left = LONG_HOLD - 1;
                pos_ch.ready <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode      = t_rx_mode'($urandom_range(0, 2));
                    mode_left = $urandom_range(16, 96);
                end
                mode_left--;
                case (mode)
                    RX_ALWAYS: pos_ch.ready <= 1'b1;
                    RX_COIN:   pos_ch.ready <= 1'($urandom_range(0, 1));
                    default:   pos_ch.ready <= (tick % 7) >= 3;
                endcase
            end
        end
    end

    // Every position transfer is checked against the oldest owed position.
    always @(posedge i_clk) begin
        t_pos want;
        if (pos_ch.valid && pos_ch.ready) begin
            if (pending_pos.size() == 0) begin
                report_mismatch($sformatf("position x=%0d y=%0d buttons=%0d not expected",
                                          pos_ch.pos_x, pos_ch.pos_y, pos_ch.buttons));
            end else begin
                want = pending_pos.pop_front();
                if (pos_ch.pos_x !== want.pos_x)
                    report_mismatch($sformatf("pos_x %0d, expected %0d",
                                              pos_ch.pos_x, want.pos_x));
                if (pos_ch.pos_y !== want.pos_y)
                    report_mismatch($sformatf("pos_y %0d, expected %0d",
                                              pos_ch.pos_y, want.pos_y));
                if (pos_ch.buttons !== want.buttons)
                    report_mismatch($sformatf("buttons %0d, expected %0d",
                                              pos_ch.buttons, want.buttons));
            end
        end
    end

    // Watchdog against a hung handshake.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        bit counted;
        i_rst_n         = 1'b0;
        byte_ch.valid   = 1'b0;
        byte_ch.rx_byte = '0;
        cfg_ch.valid    = 1'b0;
        cfg_ch.index    = ps2mpt_pkg::CFG_SCREEN_WIDTH;
        cfg_ch.data     = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table at the reset screen size of 800 by 600.
        foreach (directed_rows[i]) begin
            pace();
            send_byte(directed_rows[i].rx, directed_rows[i].typed, directed_rows[i].pos,
                      counted);
        end

        // Random phases, each under its own screen size: the full range, a single
        // pixel, zero and oversized registers that saturate, and random sizes.
        set_screen(ps2mpt_pkg::SIZE_W'(COORD_LIMIT), ps2mpt_pkg::SIZE_W'(COORD_LIMIT));
        random_traffic(PHASE_ITEMS, 1'b0);
        set_screen(ps2mpt_pkg::SIZE_W'(1), ps2mpt_pkg::SIZE_W'(1));
        random_traffic(PHASE_ITEMS, 1'b0);
        set_screen('0, '1);
        random_traffic(PHASE_ITEMS, 1'b0);
        set_screen('1, '0);
        random_traffic(PHASE_ITEMS, 1'b0);

        // Back-to-back bytes while the receiver holds off for a long stretch.
        set_screen(ps2mpt_pkg::SIZE_W'($urandom_range(1, COORD_LIMIT)),
                   ps2mpt_pkg::SIZE_W'($urandom_range(1, COORD_LIMIT)));
        full_rate = 1'b1;
        random_traffic(PHASE_ITEMS, 1'b1);
        full_rate = 1'b0;

        set_screen(ps2mpt_pkg::SIZE_W'(COORD_LIMIT + 1), ps2mpt_pkg::SIZE_W'($urandom));
        random_traffic(PHASE_ITEMS, 1'b0);

        drain_packets();
        if (error_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
